>>> rtl/bwm_pkg.sv
package bwm_pkg;

    localparam int STREAM_COUNT = 16;
    localparam int STREAM_W     = $clog2(STREAM_COUNT);

    // item modes
    localparam logic [1:0] MODE_COUNT   = 2'd0;
    localparam logic [1:0] MODE_MEASURE = 2'd1;
    localparam logic [1:0] MODE_RESET   = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD     = 1'd1;

    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd10;
    localparam logic [7:0]  OVERHEAD_RESET     = 8'd4;

    localparam int          BYTE_TO_BIT_SHIFT = 3;
    localparam logic [63:0] MS_PER_SEC        = 64'd1000;

    // divider: one quotient bit per step
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]          mode;
        logic [STREAM_W-1:0] stream_id;
        logic [15:0]         packet_bytes;
        logic [63:0]         now_ms;
    } item_t;

    typedef struct packed {
        logic [STREAM_W-1:0] out_stream;
        logic [63:0]         out_time_ms;
        logic [31:0]         bit_rate;
        logic [63:0]         packet_rate;
        logic [63:0]         interval_bytes_out;
        logic [63:0]         interval_packets_out;
        logic [63:0]         total_bytes_out;
        logic [63:0]         total_packets_out;
    } result_t;

    // one stream's table entry
    typedef struct packed {
        logic [63:0] interval_bytes;
        logic [63:0] interval_packets;
        logic [63:0] total_bytes;
        logic [63:0] total_packets;
        logic [63:0] last_time_ms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/bwm_ram.sv
module bwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bwm_div.sv
module bwm_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          divisor,
    input  logic [63:0]          dividend_a,
    input  logic [63:0]          dividend_b,
    output logic [63:0]          quot_a,
    output logic [63:0]          quot_b,
    output bwm_pkg::div_status_t status
);

    import bwm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]          d_reg;
    logic [63:0]          qa_reg, qb_reg;
    logic [31:0]          ra_reg, rb_reg;

    logic [32:0] sha, shb;
    logic        fita, fitb;
    logic [31:0] ra_next, rb_next;

    // two restoring lanes sharing divisor and step count
    always_comb
    begin
        sha     = {ra_reg, qa_reg[63]};
        shb     = {rb_reg, qb_reg[63]};
        fita    = sha >= {1'b0, d_reg};
        fitb    = shb >= {1'b0, d_reg};
        ra_next = fita ? 32'(sha - {1'b0, d_reg}) : sha[31:0];
        rb_next = fitb ? 32'(shb - {1'b0, d_reg}) : shb[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
                d_reg    <= divisor;
                qa_reg   <= dividend_a;
                qb_reg   <= dividend_b;
                ra_reg   <= '0;
                rb_reg   <= '0;
            end
            else if (busy_reg)
            begin
                ra_reg <= ra_next;
                rb_reg <= rb_next;
                qa_reg <= {qa_reg[62:0], fita};
                qb_reg <= {qb_reg[62:0], fitb};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign quot_a      = qa_reg;
    assign quot_b      = qb_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/per_stream_bandwidth_meter.sv
// Channel   Direction  Handshake                    Beat
// item      in         item_valid / item_stall      bwm_pkg::item_t
// result    out        result_valid / result_stall  bwm_pkg::result_t
// config    in         cfg_wr_en (no wait)          cfg_index, cfg_data
//
// Count, reset and unused-mode items are handled as accept with table read,
// then read-modify-write of the entry; one item is in flight at a time.
// A reporting measure adds overhead multiply, sum, scale, the 64-step divide
// and a result load that waits for a free output; a short-interval one does not.
// Reset clears the per-stream valid flags; an unwritten entry reads as zero.
// Items are taken while a result waits; a new result waits for the output.
module per_stream_bandwidth_meter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  bwm_pkg::item_t                       item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output bwm_pkg::result_t                     result,
    input  logic                                 cfg_wr_en,
    input  logic [bwm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bwm_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import bwm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_OVH,
        ST_SUM,
        ST_MUL_K,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] min_interval_reg;
    logic [7:0]  overhead_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
            overhead_reg     <= OVERHEAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                REG_OVERHEAD:     overhead_reg     <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    // captured item and measure datapath
    item_t       item_reg;
    logic [31:0] interval_reg;
    logic [63:0] ib_reg, ip_reg, tb_reg, tp_reg;
    logic [63:0] ovh_prod_reg;
    logic [63:0] bits_reg;
    logic [63:0] dvd_a_reg, dvd_b_reg;
    logic [STREAM_COUNT-1:0] valid_reg;

    // output register
    logic    out_valid_reg;
    result_t out_data_reg;

    // stream table
    logic   ram_we;
    logic   ram_re;
    entry_t ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t cur;

    bwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STREAM_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item_reg.stream_id),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item.stream_id),
        .rdata (ram_rdata)
    );

    logic accept;
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign ram_re     = accept;

    // never-written entries read as the reset value
    assign cur = valid_reg[item_reg.stream_id] ? entry_t'(ram_rdata) : '0;

    logic [31:0] interval;
    logic        rate_ok;
    assign interval = 32'(item_reg.now_ms - cur.last_time_ms);
    assign rate_ok  = (interval >= {16'd0, min_interval_reg}) && (interval != 32'd0);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = cur;
        if (state_reg == ST_READ)
        begin
            case (item_reg.mode)
                MODE_COUNT:
                begin
                    ram_we                     = 1'b1;
                    ram_wdata.interval_bytes   = cur.interval_bytes
                                               + {48'd0, item_reg.packet_bytes};
                    ram_wdata.interval_packets = cur.interval_packets + 64'd1;
                    ram_wdata.total_bytes      = cur.total_bytes
                                               + {48'd0, item_reg.packet_bytes};
                    ram_wdata.total_packets    = cur.total_packets + 64'd1;
                end
                MODE_MEASURE:
                begin
                    ram_we                     = 1'b1;
                    ram_wdata.interval_bytes   = '0;
                    ram_wdata.interval_packets = '0;
                    ram_wdata.last_time_ms     = item_reg.now_ms;
                end
                MODE_RESET:
                begin
                    ram_we                 = 1'b1;
                    ram_wdata              = '0;
                    ram_wdata.last_time_ms = item_reg.now_ms;
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    // rate divider
    logic        div_start;
    div_status_t div_stat;
    logic [63:0] quot_a, quot_b;

    assign div_start = (state_reg == ST_DIV_GO);

    bwm_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (interval_reg),
        .dividend_a (dvd_a_reg),
        .dividend_b (dvd_b_reg),
        .quot_a     (quot_a),
        .quot_b     (quot_b),
        .status     (div_stat)
    );

    logic out_free;
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_READ;
            ST_READ:    state_next = (item_reg.mode == MODE_MEASURE && rate_ok)
                                   ? ST_MUL_OVH : ST_IDLE;
            ST_MUL_OVH: state_next = ST_SUM;
            ST_SUM:     state_next = ST_MUL_K;
            ST_MUL_K:   state_next = ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV;
            ST_DIV:     if (div_stat.done) state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[item_reg.stream_id] <= 1'b1;
            end
            // a new result may replace the one leaving in the same cycle
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_valid && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= item;
                    end
                end
                ST_READ:
                begin
                    interval_reg <= interval;
                    ib_reg       <= cur.interval_bytes;
                    ip_reg       <= cur.interval_packets;
                    tb_reg       <= cur.total_bytes;
                    tp_reg       <= cur.total_packets;
                end
                ST_MUL_OVH:
                begin
                    ovh_prod_reg <= ip_reg * {56'd0, overhead_reg};
                end
                ST_SUM:
                begin
                    bits_reg <= (ib_reg + ovh_prod_reg) << BYTE_TO_BIT_SHIFT;
                end
                ST_MUL_K:
                begin
                    dvd_a_reg <= bits_reg * MS_PER_SEC;
                    dvd_b_reg <= ip_reg * MS_PER_SEC;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg.out_stream           <= item_reg.stream_id;
                        out_data_reg.out_time_ms          <= item_reg.now_ms;
                        out_data_reg.bit_rate             <= quot_a[31:0];
                        out_data_reg.packet_rate          <= quot_b;
                        out_data_reg.interval_bytes_out   <= ib_reg;
                        out_data_reg.interval_packets_out <= ip_reg;
                        out_data_reg.total_bytes_out      <= tb_reg;
                        out_data_reg.total_packets_out    <= tp_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // a new result only comes out of the divider's completion state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished measurement");

    // table is written only in the read-modify-write cycle
    a_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_READ))
        else $error("table write outside read-modify-write");

    // divider runs only while the sequencer waits for it
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    // no item taken while a measurement is in its divide state
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> !accept)
        else $error("item accepted during divide");

endmodule
